>>> hdl/comment_whitespace_stripper_assert.svh
// assertion macros shared by the stripper modules
`ifndef COMMENT_WHITESPACE_STRIPPER_ASSERT_SVH
`define COMMENT_WHITESPACE_STRIPPER_ASSERT_SVH

// expression must hold at every clock edge outside reset
`define CWS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cws_pkg.sv
`timescale 1ns / 1ps

package cws_pkg;

  // characters with a role in the scan
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       kept;
    logic       last;
  } res_t;

  // everything one input byte produces
  typedef struct packed {
    logic any;   // at least one result
    logic two;   // a second result follows the first
    res_t first;
    res_t second;
  } scan_t;

  // c-locale whitespace
  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

>>> hdl/cws_if.sv
`timescale 1ns / 1ps

// raw text byte channel
interface cws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// stripped result channel
interface cws_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_last,
                  output ready);
endinterface

>>> hdl/cws_scan.sv
`timescale 1ns / 1ps
`include "comment_whitespace_stripper_assert.svh"

module cws_scan
  import cws_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] c_in,
  input  logic       last_in,
  output scan_t      res
);

  logic string_r, string_nxt;
  logic comment_r, comment_nxt;
  logic slash_r, slash_nxt;
  logic star_r, star_nxt;

  logic is_slash, is_star, is_quote;
  logic handled, emit_slash, emit_c;

  assign is_slash = (c_in == CH_SLASH);
  assign is_star  = (c_in == CH_STAR);
  assign is_quote = (c_in == CH_QUOTE);

  // decide what this byte emits and how the scan state moves
  always_comb begin
    emit_slash  = 1'b0;
    emit_c      = 1'b0;
    string_nxt  = string_r;
    comment_nxt = comment_r;
    slash_nxt   = 1'b0;
    handled     = slash_r && is_star;

    // a held slash resolves now
    if (slash_r) begin
      if (is_star) begin
        comment_nxt = 1'b1;
      end else begin
        emit_slash = 1'b1;
      end
    end

    if (!handled) begin
      if (comment_r) begin
        if (is_slash && star_r) begin
          comment_nxt = 1'b0;
        end
      end else if (string_r) begin
        emit_c = 1'b1;
        if (is_quote) begin
          string_nxt = 1'b0;
        end
      end else if (is_quote) begin
        string_nxt = 1'b1;
        emit_c     = 1'b1;
      end else if (is_slash) begin
        if (last_in) begin
          emit_c = 1'b1;
        end else begin
          slash_nxt = 1'b1;
        end
      end else if (!is_blank(c_in)) begin
        emit_c = 1'b1;
      end
    end

    star_nxt = is_star;

    // end of text starts a fresh scan
    if (last_in) begin
      string_nxt  = 1'b0;
      comment_nxt = 1'b0;
      slash_nxt   = 1'b0;
      star_nxt    = 1'b0;
    end
  end

  // result items
  always_comb begin
    res.any          = emit_slash || emit_c || last_in;
    res.two          = emit_slash && emit_c;
    res.first.data   = emit_slash ? CH_SLASH : (emit_c ? c_in : 8'h00);
    res.first.kept   = emit_slash || emit_c;
    res.first.last   = last_in && !(emit_slash && emit_c);
    res.second.data  = c_in;
    res.second.kept  = 1'b1;
    res.second.last  = last_in;
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      string_r  <= 1'b0;
      comment_r <= 1'b0;
      slash_r   <= 1'b0;
      star_r    <= 1'b0;
    end else if (step) begin
      string_r  <= string_nxt;
      comment_r <= comment_nxt;
      slash_r   <= slash_nxt;
      star_r    <= star_nxt;
    end
  end

  `CWS_ASSERT_ALWAYS(a_str_com_excl, !(string_r && comment_r), "string and comment both open")
  `CWS_ASSERT_IMP(a_slash_outside, slash_r, !string_r && !comment_r, "slash held inside text")
  `CWS_ASSERT_NEXT(a_last_clears, step && last_in, !slash_r && !string_r && !comment_r, "state kept past last")

endmodule

>>> hdl/comment_whitespace_stripper.sv
`timescale 1ns / 1ps
`include "comment_whitespace_stripper_assert.svh"

// Strips whitespace and slash-star block comments from a byte stream outside
// double-quoted strings. One byte is taken per cycle while in_chan.ready is
// high; the first result of each byte is registered in the output register. A
// byte that releases a held slash and is itself kept yields two results, the
// second waiting in one overflow stage behind the output register, so the input
// is held off until that overflow stage has drained. The last byte of a text
// always yields a result with out_last set, carrying no byte when nothing is
// kept, and returns the scan to its starting state.
module comment_whitespace_stripper
  import cws_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  cws_in_if.sink          in_chan,
  cws_out_if.source       out_chan
);

  scan_t scan;
  logic  accept, take;

  logic  out_v_r, out_v_nxt;
  res_t  out_res_r, out_res_nxt;
  logic  pend_v_r, pend_v_nxt;
  res_t  pend_res_r, pend_res_nxt;

  // room for two results once the output is free this cycle
  assign in_chan.ready = !pend_v_r && (!out_v_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;
  assign take          = out_v_r && out_chan.ready;

  cws_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .c_in    (in_chan.in_byte),
    .last_in (in_chan.in_last),
    .res     (scan)
  );

  // output register and overflow stage
  always_comb begin
    out_v_nxt    = out_v_r && !take;
    out_res_nxt  = out_res_r;
    pend_v_nxt   = pend_v_r;
    pend_res_nxt = pend_res_r;
    if (accept) begin
      if (scan.any) begin
        out_v_nxt   = 1'b1;
        out_res_nxt = scan.first;
      end
      if (scan.two) begin
        pend_v_nxt   = 1'b1;
        pend_res_nxt = scan.second;
      end
    end else if (take && pend_v_r) begin
      out_v_nxt   = 1'b1;
      out_res_nxt = pend_res_r;
      pend_v_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    pend_res_r <= pend_res_nxt;
  end

  assign out_chan.valid     = out_v_r;
  assign out_chan.out_byte  = out_res_r.data;
  assign out_chan.out_valid = out_res_r.kept;
  assign out_chan.out_last  = out_res_r.last;

  `CWS_ASSERT_IMP(a_pend_behind_out, pend_v_r, out_v_r, "overflow stage filled ahead of output")
  `CWS_ASSERT_IMP(a_no_accept_pend, pend_v_r, !in_chan.ready, "input open with result waiting")
  `CWS_ASSERT_NEXT(a_pend_moves, take && pend_v_r, out_v_r && !pend_v_r, "overflow result lost")

endmodule
